// ===== hdl/keyed_slot_light_table_core_assert.svh =====
// Assertion macros for the keyed slot light table.
// Used by the top level only; no other dependencies.
`ifndef KEYED_SLOT_LIGHT_TABLE_CORE_ASSERT_SVH
`define KEYED_SLOT_LIGHT_TABLE_CORE_ASSERT_SVH
// Implication check under clock and async reset.
`define KSLT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication check.
`define KSLT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== hdl/kslt_pkg.sv =====
// Shared types and constants for the keyed slot light table.
// No dependencies.
package kslt_pkg;
	localparam int SLOTS_DEF = 32;
	localparam logic [1:0] OP_NEW   = 2'd0;
	localparam logic [1:0] OP_TICK  = 2'd1;
	localparam logic [1:0] OP_LIST  = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	// ceil(2^36 / 1000): elapsed * decay * this, shifted down 36, is an exact
	// floor of elapsed * decay / 1000 over the whole input range
	localparam logic [26:0] DECAY_RECIP = 27'd68719477;

	// One slot record, as it moves along the ring of cells.
	typedef struct packed {
		logic [15:0] key;
		logic [31:0] die;
		logic [15:0] radius;
		logic [15:0] decay;
		logic [47:0] pos;
		logic [23:0] color;
	} slot_rec_t;

	// Per-cycle command to every cell.
	typedef struct packed {
		logic shift;   // rotate the ring by one place
		logic clear;   // zero every cell
	} cell_ctl_t;
endpackage

// ===== hdl/kslt_cell.sv =====
// One slot storage cell of the rotating ring.
// Depends on kslt_pkg.
module kslt_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  kslt_pkg::cell_ctl_t ctl,
	input  kslt_pkg::slot_rec_t rec_in,
	output kslt_pkg::slot_rec_t rec_out
);
	kslt_pkg::slot_rec_t rec_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q <= '0;
		end else if (ctl.clear) begin
			rec_q <= '0;
		end else if (ctl.shift) begin
			rec_q <= rec_in;
		end
	end
	assign rec_out = rec_q;
endmodule

// ===== hdl/kslt_decay.sv =====
// Radius update for a tick: expiry, loss = floor(el*decay/1000), saturate.
// Depends on kslt_pkg. Combinational, one reciprocal multiply per slot.
module kslt_decay (
	input  logic [31:0]         now_ms,
	input  logic [36:0]         scale,
	input  kslt_pkg::slot_rec_t rec_in,
	output kslt_pkg::slot_rec_t rec_out
);
	logic [52:0] prod;
	logic [16:0] loss;
	always_comb begin
		// scale holds elapsed times the reciprocal of 1000 in 36 fraction bits
		prod    = 53'(rec_in.decay) * 53'(scale);
		loss    = prod[52:36];
		rec_out = rec_in;
		if (rec_in.radius != '0) begin
			if (rec_in.die < now_ms) begin
				rec_out.radius = '0;
			end else if (loss >= 17'(rec_in.radius)) begin
				rec_out.radius = '0;
			end else begin
				rec_out.radius = rec_in.radius - loss[15:0];
			end
		end
	end
endmodule

// ===== hdl/keyed_slot_light_table_core.sv =====
// Keyed slot light table: a ring of SLOTS cells that rotates one place per
// cycle past the head cell during a turn, unless a list holds it; at the head
// each slot is matched, decayed or listed. One request is taken at a time,
// only while the block is idle and the result register is free. A new light
// takes two full turns (search, then write) and then loads its result in the
// hold state. A tick or a list takes one turn and then the hold state, and a
// list stops its turn while a finished result waits on a stalled output.
// Clear zeroes every cell; its acknowledgment is loaded at the accept edge.
// Depends on kslt_pkg, kslt_cell, kslt_decay and the assertion header.
`include "keyed_slot_light_table_core_assert.svh"
module keyed_slot_light_table_core #(
	parameter int SLOTS = kslt_pkg::SLOTS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// light_key, pos_x, pos_y, pos_z, start_radius, lifetime_ms, decay_rate,
	// color_r, color_g, color_b, elapsed_ms[9:0], pad 6
	input  logic [151:0] s_tdata,
	// operation[1:0]
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// slot[4:0], out_x, out_y, out_z, out_radius, out_red, out_green,
	// out_blue, pad 3
	output logic [95:0]  m_tdata,
	// has_light
	output logic         m_tuser,
	output logic         m_tlast
);
	localparam int IW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);

	typedef enum logic [2:0] {ST_IDLE, ST_FIND, ST_WRITE, ST_TICK, ST_LIST, ST_HOLD}
		state_t;
	state_t state_q;

	logic [9:0]    r_el;
	logic [135:0]  req_q;
	logic [1:0]    op_q;
	logic [15:0]   q_key;
	logic [31:0]   now_q;
	logic [36:0]   scale_q;
	logic [CW-1:0] cnt_q;
	logic          key_hit_q, exp_hit_q;
	logic [IW-1:0] key_idx_q, exp_idx_q, sel_q;
	logic [5:0]    nlist_q;
	logic          pend_q;   // a list result held until the next one shows up
	logic [92:0]   lbuf_q;

	kslt_pkg::slot_rec_t ring [SLOTS];
	kslt_pkg::slot_rec_t feed, decayed, head, wr_rec;
	kslt_pkg::cell_ctl_t ctl;

	logic [IW-1:0] pos_idx;
	logic [92:0]   head_word, wr_word;
	logic          out_free;
	logic          list_emit;
	logic          last_turn;
	logic          out_load;
	logic [95:0]   out_data;
	logic          out_user;
	logic          out_last;

	assign r_el  = s_tdata[145:136];
	assign q_key = req_q[15:0];

	// Head is cell 0; data flows from cell i+1 to cell i, head feeds last cell.
	assign head = ring[0];
	genvar g;
	generate
		for (g = 0; g < SLOTS; g++) begin : g_cell
			kslt_pkg::slot_rec_t nin;
			if (g == SLOTS - 1) begin : g_tail
				assign nin = feed;
			end else begin : g_mid
				assign nin = ring[g + 1];
			end
			kslt_cell u_cell (.clk(clk), .arst_n(arst_n), .ctl(ctl), .rec_in(nin),
				.rec_out(ring[g]));
		end
	endgenerate

	kslt_decay u_decay (.now_ms(now_q), .scale(scale_q), .rec_in(head),
		.rec_out(decayed));

	assign pos_idx = cnt_q[IW-1:0];

	always_comb begin
		wr_rec.key    = req_q[15:0];
		wr_rec.pos    = req_q[63:16];
		wr_rec.radius = req_q[79:64];
		wr_rec.die    = now_q + 32'(req_q[95:80]);
		wr_rec.decay  = req_q[111:96];
		wr_rec.color  = req_q[135:112];
	end

	assign head_word = {head.color, head.radius, head.pos, 5'(pos_idx)};
	assign wr_word   = {wr_rec.color, wr_rec.radius, wr_rec.pos, 5'(sel_q)};

	assign out_free  = !m_tvalid || m_tready;
	assign list_emit = state_q == ST_LIST && head.radius != '0 && nlist_q != 6'd32;
	assign last_turn = cnt_q == CW'(SLOTS - 1);

	always_comb begin
		ctl.clear = state_q == ST_IDLE && s_tvalid && s_tready &&
			s_tuser == kslt_pkg::OP_CLEAR;
		ctl.shift = 1'b0;
		feed      = head;
		unique case (state_q)
			ST_FIND: ctl.shift = 1'b1;
			ST_TICK: begin
				ctl.shift = 1'b1;
				feed      = decayed;
			end
			ST_WRITE: begin
				ctl.shift = 1'b1;
				if (pos_idx == sel_q) feed = wr_rec;
			end
			// hold the turn while a new result meets a held one that cannot be pushed out
			ST_LIST: ctl.shift = !list_emit || !pend_q || out_free;
			default: ctl.shift = 1'b0;
		endcase
	end

	always_comb begin
		out_load = 1'b0;
		out_data = '0;
		out_user = 1'b0;
		out_last = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				if (ctl.clear) out_load = 1'b1;
			end
			ST_LIST: begin
				if (list_emit && pend_q && out_free) begin
					out_load = 1'b1;
					out_data = 96'(lbuf_q);
					out_user = 1'b1;
					out_last = 1'b0;
				end
			end
			ST_HOLD: begin
				if (out_free) begin
					out_load = 1'b1;
					if (op_q == kslt_pkg::OP_NEW) begin
						out_data = 96'(wr_word);
						out_user = 1'b1;
					end else if (op_q == kslt_pkg::OP_LIST && pend_q) begin
						out_data = 96'(lbuf_q);
						out_user = 1'b1;
					end
				end
			end
			default: out_load = 1'b0;
		endcase
	end

	assign s_tready = state_q == ST_IDLE && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			now_q     <= '0;
			scale_q   <= '0;
			cnt_q     <= '0;
			m_tvalid  <= 1'b0;
			m_tlast   <= 1'b0;
			m_tdata   <= '0;
			m_tuser   <= 1'b0;
			key_hit_q <= 1'b0;
			exp_hit_q <= 1'b0;
			key_idx_q <= '0;
			exp_idx_q <= '0;
			sel_q     <= '0;
			nlist_q   <= '0;
			pend_q    <= 1'b0;
			lbuf_q    <= '0;
			req_q     <= '0;
			op_q      <= kslt_pkg::OP_NEW;
		end else begin
			if (out_load) begin
				m_tvalid <= 1'b1;
				m_tdata  <= out_data;
				m_tuser  <= out_user;
				m_tlast  <= out_last;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid && s_tready) begin
						req_q     <= s_tdata[135:0];
						op_q      <= s_tuser;
						cnt_q     <= '0;
						key_hit_q <= 1'b0;
						exp_hit_q <= 1'b0;
						nlist_q   <= '0;
						pend_q    <= 1'b0;
						unique case (s_tuser)
							kslt_pkg::OP_NEW: state_q <= ST_FIND;
							kslt_pkg::OP_TICK: begin
								now_q   <= now_q + 32'(r_el);
								scale_q <= 37'(r_el) * 37'(kslt_pkg::DECAY_RECIP);
								state_q <= ST_TICK;
							end
							kslt_pkg::OP_LIST: state_q <= ST_LIST;
							kslt_pkg::OP_CLEAR: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_FIND: begin
					if (!key_hit_q && q_key != '0 && head.key == q_key) begin
						key_hit_q <= 1'b1;
						key_idx_q <= pos_idx;
					end
					if (!exp_hit_q && head.die < now_q) begin
						exp_hit_q <= 1'b1;
						exp_idx_q <= pos_idx;
					end
					cnt_q <= last_turn ? '0 : cnt_q + CW'(1);
					if (last_turn) begin
						state_q <= ST_WRITE;
						sel_q   <= key_hit_q ? key_idx_q :
							(q_key != '0 && head.key == q_key) ? pos_idx :
							exp_hit_q ? exp_idx_q : (head.die < now_q) ? pos_idx : '0;
					end
				end
				ST_WRITE: begin
					cnt_q <= last_turn ? '0 : cnt_q + CW'(1);
					if (last_turn) state_q <= ST_HOLD;
				end
				ST_HOLD: begin
					if (out_free) begin
						pend_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				ST_TICK: begin
					cnt_q <= last_turn ? '0 : cnt_q + CW'(1);
					if (last_turn) state_q <= ST_HOLD;
				end
				ST_LIST: begin
					if (ctl.shift) begin
						if (list_emit) begin
							lbuf_q  <= head_word;
							pend_q  <= 1'b1;
							nlist_q <= nlist_q + 6'd1;
						end
						cnt_q <= last_turn ? '0 : cnt_q + CW'(1);
						// the held result, or an ack, goes out as the last one
						if (last_turn) state_q <= ST_HOLD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`KSLT_ASSERT_IMPL(a_ready_idle, clk, arst_n, s_tready, state_q == ST_IDLE, "ready outside idle")
	`KSLT_ASSERT_NEXT(a_clear_zero, clk, arst_n, ctl.clear, ring[0].radius == '0, "clear left radius")
	`KSLT_ASSERT_IMPL(a_last_ack, clk, arst_n, m_tvalid && !m_tuser, m_tlast, "ack without last")
	`KSLT_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for keyed_slot_light_table_core: stream requests in,
// predicts each result from its own copy of the slot table, compares in order.
// Depends on kslt_pkg and the core RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NSLOT = 32;

	typedef struct {
		logic [1:0]  op;
		logic [15:0] key;
		logic [15:0] px, py, pz;
		logic [15:0] radius;
		logic [15:0] lifetime;
		logic [15:0] decay;
		logic [7:0]  red, green, blue;
		logic [9:0]  elapsed;
	} light_req_t;

	typedef struct {
		logic [4:0]  slot;
		logic [15:0] x, y, z;
		logic [15:0] radius;
		logic [7:0]  red, green, blue;
		logic        has_light;
		logic        last;
	} light_res_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [151:0] s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [95:0]  m_tdata;
	logic         m_tuser;
	logic         m_tlast;

	keyed_slot_light_table_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	// shadow table
	logic [31:0] now_ms;
	logic [15:0] tbl_key    [NSLOT];
	logic [31:0] tbl_die    [NSLOT];
	logic [15:0] tbl_radius [NSLOT];
	logic [15:0] tbl_decay  [NSLOT];
	logic [47:0] tbl_pos    [NSLOT];
	logic [23:0] tbl_color  [NSLOT];

	light_res_t pending_lights[$];
	int errors;
	int req_count;
	int light_results;
	int list_count;
	int expired_count;
	bit calm;
	int hold_left;
	int stall_left;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("Timeout waiting for results");
		$display("Some tests failed");
		$finish;
	end

	function automatic logic [151:0] pack_req(light_req_t r);
		logic [151:0] d;
		d = '0;
		d[15:0]    = r.key;
		d[31:16]   = r.px;
		d[47:32]   = r.py;
		d[63:48]   = r.pz;
		d[79:64]   = r.radius;
		d[95:80]   = r.lifetime;
		d[111:96]  = r.decay;
		d[119:112] = r.red;
		d[127:120] = r.green;
		d[135:128] = r.blue;
		d[145:136] = r.elapsed;
		return d;
	endfunction

	function automatic void clear_shadow();
		for (int i = 0; i < NSLOT; i++) begin
			tbl_key[i] = '0; tbl_die[i] = '0; tbl_radius[i] = '0;
			tbl_decay[i] = '0; tbl_pos[i] = '0; tbl_color[i] = '0;
		end
	endfunction

	function automatic light_res_t slot_result(int s, logic is_last);
		light_res_t e;
		e.slot = s[4:0];
		e.x = tbl_pos[s][15:0];
		e.y = tbl_pos[s][31:16];
		e.z = tbl_pos[s][47:32];
		e.radius = tbl_radius[s];
		e.red = tbl_color[s][7:0];
		e.green = tbl_color[s][15:8];
		e.blue = tbl_color[s][23:16];
		e.has_light = 1'b1;
		e.last = is_last;
		return e;
	endfunction

	function automatic light_res_t ack_result();
		light_res_t e;
		e = '{default: '0};
		e.last = 1'b1;
		return e;
	endfunction

	// advance the shadow table by one request and queue what it should emit
	function automatic void predict_lights(light_req_t r);
		int s;
		int n;
		logic [31:0] loss;
		case (r.op)
			kslt_pkg::OP_NEW: begin
				s = -1;
				if (r.key != 0)
					for (int i = 0; i < NSLOT && s < 0; i++)
						if (tbl_key[i] == r.key) s = i;
				for (int i = 0; i < NSLOT && s < 0; i++)
					if (tbl_die[i] < now_ms) s = i;
				if (s < 0) s = 0;
				tbl_key[s] = r.key;
				tbl_pos[s] = {r.pz, r.py, r.px};
				tbl_radius[s] = r.radius;
				tbl_die[s] = now_ms + {16'd0, r.lifetime};
				tbl_decay[s] = r.decay;
				tbl_color[s] = {r.blue, r.green, r.red};
				pending_lights.push_back(slot_result(s, 1'b1));
			end
			kslt_pkg::OP_TICK: begin
				now_ms = now_ms + {22'd0, r.elapsed};
				for (int i = 0; i < NSLOT; i++) begin
					if (tbl_radius[i] == 0) continue;
					if (tbl_die[i] < now_ms) begin
						tbl_radius[i] = 0;
						expired_count++;
						continue;
					end
					loss = ({22'd0, r.elapsed} * {16'd0, tbl_decay[i]}) / 1000;
					if (loss >= {16'd0, tbl_radius[i]}) tbl_radius[i] = 0;
					else tbl_radius[i] = tbl_radius[i] - loss[15:0];
				end
				pending_lights.push_back(ack_result());
			end
			kslt_pkg::OP_LIST: begin
				n = 0;
				for (int i = 0; i < NSLOT; i++) n += (tbl_radius[i] != 0);
				if (n == 0) pending_lights.push_back(ack_result());
				for (int i = 0; i < NSLOT; i++)
					if (tbl_radius[i] != 0) begin
						n--;
						pending_lights.push_back(slot_result(i, n == 0));
					end
				list_count++;
			end
			default: begin
				clear_shadow();
				pending_lights.push_back(ack_result());
			end
		endcase
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
		errors++;
	endtask

	// hold the request for the handshake, then update the shadow table
	task automatic send_req(light_req_t r);
		if (!calm && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		s_tdata <= pack_req(r);
		s_tuser <= r.op;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		predict_lights(r);
		req_count++;
	endtask

	function automatic light_req_t make_req(logic [1:0] op);
		light_req_t r;
		r = '{default: '0};
		r.op = op;
		return r;
	endfunction

	function automatic light_req_t make_light(logic [15:0] key, logic [15:0] radius,
	                                          logic [15:0] lifetime, logic [15:0] decay);
		light_req_t r;
		r.op = kslt_pkg::OP_NEW;
		r.key = key;
		r.px = 16'($urandom()); r.py = 16'($urandom()); r.pz = 16'($urandom());
		r.radius = radius;
		r.lifetime = lifetime;
		r.decay = decay;
		r.red = 8'($urandom()); r.green = 8'($urandom()); r.blue = 8'($urandom());
		r.elapsed = 10'($urandom());
		return r;
	endfunction

	function automatic light_req_t make_tick(logic [9:0] ms);
		light_req_t r;
		r = make_req(kslt_pkg::OP_TICK);
		r.elapsed = ms;
		return r;
	endfunction

	// empty list, keyless lights on a fresh table, field extremes
	task automatic test_fresh_table();
		light_req_t r;
		send_req(make_req(kslt_pkg::OP_LIST));
		r = make_light(16'd0, 16'hFFFF, 16'hFFFF, 16'd0);
		r.px = 16'h8000; r.py = 16'h7FFF; r.pz = 16'hFFFF;
		r.red = 8'hFF; r.green = 8'h00; r.blue = 8'hFF;
		send_req(r);
		r = make_light(16'd0, 16'd1, 16'd0, 16'hFFFF);
		r.px = 16'h7FFF; r.py = 16'h8000; r.pz = 16'h0000;
		r.red = 8'h00; r.green = 8'hFF; r.blue = 8'h00;
		send_req(r);
		send_req(make_tick(10'd0));
		send_req(make_req(kslt_pkg::OP_LIST));
	endtask

	// key reuse, expiry that must not stop the pass, decay saturation, clear
	task automatic test_keys_and_expiry();
		send_req(make_req(kslt_pkg::OP_CLEAR));
		send_req(make_light(16'hFFFF, 16'h0100, 16'd5000, 16'd0));
		send_req(make_light(16'd1, 16'h0200, 16'd0, 16'd100));
		send_req(make_light(16'd2, 16'h0010, 16'd5000, 16'hFFFF));
		send_req(make_light(16'd3, 16'h8000, 16'd5000, 16'd1000));
		send_req(make_tick(10'd1023));
		send_req(make_req(kslt_pkg::OP_LIST));
		send_req(make_light(16'd0, 16'h0300, 16'd100, 16'd7));
		send_req(make_light(16'hFFFF, 16'h0400, 16'd200, 16'd9));
		send_req(make_light(16'd3, 16'h0500, 16'd300, 16'd11));
		send_req(make_tick(10'd1));
		send_req(make_req(kslt_pkg::OP_LIST));
		send_req(make_req(kslt_pkg::OP_CLEAR));
		send_req(make_req(kslt_pkg::OP_LIST));
	endtask

	// fill every slot, list all of them, then stall the output for a long stretch
	task automatic test_full_table_backpressure();
		for (int i = 0; i < NSLOT; i++)
			send_req(make_light(16'd100 + i[15:0], 16'($urandom_range(1, 65535)),
				16'hFFFF, 16'($urandom_range(0, 20))));
		send_req(make_req(kslt_pkg::OP_LIST));
		hold_left = 400;
		repeat (5) send_req(make_req(kslt_pkg::OP_LIST));
		send_req(make_tick(10'($urandom_range(0, 1023))));
		send_req(make_req(kslt_pkg::OP_LIST));
	endtask

	function automatic light_req_t random_req();
		light_req_t r;
		int pick;
		int kind;
		pick = $urandom_range(0, 99);
		kind = $urandom_range(0, 9);
		r = make_light(16'($urandom_range(0, 8)), 16'($urandom()),
			16'($urandom_range(0, 3000)), 16'($urandom_range(0, 2000)));
		// a slice of full-range noise so every field bit toggles
		if (kind == 0) begin
			r.key = 16'($urandom()); r.lifetime = 16'($urandom()); r.decay = 16'($urandom());
		end
		if (pick < 50) r.op = kslt_pkg::OP_NEW;
		else if (pick < 76) r.op = kslt_pkg::OP_TICK;
		else if (pick < 94) r.op = kslt_pkg::OP_LIST;
		else r.op = kslt_pkg::OP_CLEAR;
		return r;
	endfunction

	task automatic test_random_mix();
		for (int i = 0; i < 320; i++) begin
			if (i == 260) calm = 1'b1;
			send_req(random_req());
		end
	endtask

	// output side: random stalls plus the long hold-off when requested
	initial begin
		m_tready = 1'b0;
		stall_left = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
				if (!calm && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 17);
			end
		end
	end

	always @(posedge clk) begin
		light_res_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_lights.size() == 0) begin
				$display("[%0t] result with no request outstanding", $realtime);
				errors++;
			end else begin
				e = pending_lights.pop_front();
				if (m_tdata[4:0] !== e.slot)
					report_mismatch("slot", 32'(m_tdata[4:0]), 32'(e.slot));
				if (m_tdata[20:5] !== e.x)
					report_mismatch("out_x", 32'(m_tdata[20:5]), 32'(e.x));
				if (m_tdata[36:21] !== e.y)
					report_mismatch("out_y", 32'(m_tdata[36:21]), 32'(e.y));
				if (m_tdata[52:37] !== e.z)
					report_mismatch("out_z", 32'(m_tdata[52:37]), 32'(e.z));
				if (m_tdata[68:53] !== e.radius)
					report_mismatch("out_radius", 32'(m_tdata[68:53]), 32'(e.radius));
				if (m_tdata[76:69] !== e.red)
					report_mismatch("out_red", 32'(m_tdata[76:69]), 32'(e.red));
				if (m_tdata[84:77] !== e.green)
					report_mismatch("out_green", 32'(m_tdata[84:77]), 32'(e.green));
				if (m_tdata[92:85] !== e.blue)
					report_mismatch("out_blue", 32'(m_tdata[92:85]), 32'(e.blue));
				if (m_tuser !== e.has_light)
					report_mismatch("has_light", 32'(m_tuser), 32'(e.has_light));
				if (m_tlast !== e.last) report_mismatch("last", 32'(m_tlast), 32'(e.last));
				if (e.has_light) light_results++;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		errors = 0;
		req_count = 0;
		light_results = 0;
		list_count = 0;
		expired_count = 0;
		calm = 1'b0;
		now_ms = '0;
		clear_shadow();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_fresh_table();
		test_keys_and_expiry();
		test_full_table_backpressure();
		test_random_mix();

		s_tvalid <= 1'b0;
		while (pending_lights.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (pending_lights.size() != 0) begin
			$display("%0d results never arrived", pending_lights.size());
			errors++;
		end

		$display("Sent %0d requests (%0d lists), checked %0d slot results, %0d lights expired",
			req_count, list_count, light_results, expired_count);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/kslt_pkg.sv
hdl/kslt_cell.sv
hdl/kslt_decay.sv
hdl/keyed_slot_light_table_core.sv
dv/tb_top.sv
